FILE: hw/rtl/ansi_escape_stream_parser_unit_defines.svh
// Assertion macros for the escape stream parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ANSI_ESCAPE_STREAM_PARSER_UNIT_DEFINES_SVH
`define ANSI_ESCAPE_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AESP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aesp same-cycle check failed");

// next-cycle implication, disabled during reset
`define AESP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aesp next-cycle check failed");

`endif

FILE: hw/rtl/aesp_pkg.sv
// Shared types and byte codes for the escape stream parser.
// No dependencies; used by the stream interfaces and the top level.
`default_nettype none

package aesp_pkg;

    localparam int WORD_W  = 16;
    localparam int PHASE_W = 2;
    localparam int CNT_W   = 3;
    localparam int TAB_STOP = 4;
    localparam int DEC_BASE = 10;

    localparam logic [WORD_W-1:0] SAT_MAX = '1;

    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;
    localparam logic [7:0] CHR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHR_LPAREN  = 8'h28;
    localparam logic [7:0] CHR_DIG0    = 8'h30;
    localparam logic [7:0] CHR_DIG9    = 8'h39;
    localparam logic [7:0] CHR_SEMI    = 8'h3B;
    localparam logic [7:0] CHR_SGR     = 8'h6D;
    localparam logic [7:0] CHR_FWD     = 8'h43;
    localparam logic [7:0] CHR_BACK    = 8'h44;

    typedef enum logic [1:0] {
        EV_PRINT   = 2'd0,
        EV_NEWLINE = 2'd1,
        EV_STYLE   = 2'd2,
        EV_CURSOR  = 2'd3
    } t_event_kind;

endpackage

`default_nettype wire

FILE: hw/rtl/aesp_in_if.sv
// Input byte stream: valid/ready handshake with one byte per beat.
// Depends on aesp_pkg.
`default_nettype none

interface aesp_in_if import aesp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       block_end;

    modport source (output valid, output byte_value, output block_end, input ready);
    modport sink   (input valid, input byte_value, input block_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/aesp_out_if.sv
// Output event stream: valid/ready handshake with one event per beat.
// Depends on aesp_pkg.
`default_nettype none

interface aesp_out_if import aesp_pkg::*; ();
    logic              valid;
    logic              ready;
    t_event_kind       event_kind;
    logic [7:0]        char_code;
    logic [WORD_W-1:0] style_param;
    logic [WORD_W-1:0] column;
    logic [WORD_W-1:0] row;
    logic              last_of_run;

    modport source (output valid, output event_kind, output char_code, output style_param,
                    output column, output row, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input char_code, input style_param,
                    input column, input row, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ansi_escape_stream_parser_unit.sv
// Escape stream parser: terminal output bytes in, print/newline/style/cursor events out.
// Depends on aesp_pkg, aesp_in_if, aesp_out_if and the assertion macro header.
//
// One byte is taken per beat and a new byte can be accepted every cycle while the
// event register is free or its last beat is taken. A byte is held in the input
// register; the parser logic then updates its state and loads the event register,
// from which the events of the byte are shown. Most bytes give zero or one event;
// a tab gives one to four space events (up to the next multiple of four in the
// current text chunk), and those repeat out of the event register one per cycle
// while the output is ready, so a tab holds the input side while they drain.
// Bytes that cause no event pass through the input register with nothing shown
// on the output. last_of_run marks the final event of each byte. CSI parameters
// saturate at 65535, as do the row and a forward cursor move; a backward move
// clamps at column 0. block_end zeroes the tab chunk phase after its byte. No
// clearing pass is needed after reset.
`default_nettype none
`include "ansi_escape_stream_parser_unit_defines.svh"

module ansi_escape_stream_parser_unit
    import aesp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    aesp_in_if.sink     i_in,
    aesp_out_if.source  o_out
);

    // one-hot parser states
    typedef enum logic [3:0] {
        ST_TEXT = 4'b0001,
        ST_ESC  = 4'b0010,
        ST_CSI  = 4'b0100,
        ST_FONT = 4'b1000
    } t_parse_state;

    localparam int ACC_W = WORD_W + 4;   // holds 65535 * 10 + 9
    localparam logic [CNT_W-1:0] TAB_CNT = CNT_W'(TAB_STOP);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;

    // parser state
    t_parse_state      r_state, n_state;
    logic [WORD_W-1:0] r_accum, n_accum;
    logic [WORD_W-1:0] r_col, n_col;
    logic [WORD_W-1:0] r_row, n_row;
    logic [PHASE_W-1:0] r_phase, n_phase;

    // event register; r_rem counts beats still to show, 0 means empty
    logic [CNT_W-1:0]  r_rem;
    t_event_kind       r_kind;
    logic [7:0]        r_char;
    logic [WORD_W-1:0] r_param;
    logic [WORD_W-1:0] r_ev_col;
    logic [WORD_W-1:0] r_ev_row;

    // events of the byte in the input register
    logic [CNT_W-1:0]  ev_cnt;
    t_event_kind       ev_kind;
    logic [7:0]        ev_char;
    logic [WORD_W-1:0] ev_param;

    logic              advance;
    logic              in_fire;
    logic [ACC_W-1:0]  dec_sum;
    logic [WORD_W:0]   fwd_sum;

    // input byte moves on once the event register is empty or its last beat is taken
    assign advance = r_in_valid && ((r_rem == '0) || (o_out.ready && r_rem == CNT_W'(1)));
    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    // accum * 10 + digit, as shifts and adds
    assign dec_sum = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                   + ACC_W'(r_in_byte - CHR_DIG0);
    assign fwd_sum = {1'b0, r_col} + {1'b0, r_accum};

    always_comb begin
        n_state  = r_state;
        n_accum  = r_accum;
        n_col    = r_col;
        n_row    = r_row;
        n_phase  = r_phase;
        ev_cnt   = '0;
        ev_kind  = EV_PRINT;
        ev_char  = '0;
        ev_param = '0;

        unique case (r_state)
            ST_TEXT: begin
                if (r_in_byte == BYTE_ESC) begin
                    n_phase = '0;
                    n_state = ST_ESC;
                end else if (r_in_byte == BYTE_LF) begin
                    n_phase = '0;
                    n_col   = '0;
                    if (r_row != SAT_MAX) begin
                        n_row = r_row + WORD_W'(1);
                    end
                    ev_cnt  = CNT_W'(1);
                    ev_kind = EV_NEWLINE;
                end else if (r_in_byte == BYTE_TAB) begin
                    ev_cnt  = TAB_CNT - CNT_W'(r_phase);
                    ev_char = BYTE_SPACE;
                    n_phase = '0;
                end else if (r_in_byte >= PRINT_LO && r_in_byte <= PRINT_HI) begin
                    ev_cnt  = CNT_W'(1);
                    ev_char = r_in_byte;
                    n_phase = r_phase + PHASE_W'(1);
                end
            end
            ST_ESC: begin
                n_accum = '0;
                if (r_in_byte == CHR_LBRACK) begin
                    n_state = ST_CSI;
                end else if (r_in_byte == CHR_LPAREN) begin
                    n_state = ST_FONT;
                end
            end
            ST_CSI: begin
                if (r_in_byte >= CHR_DIG0 && r_in_byte <= CHR_DIG9) begin
                    n_accum = (dec_sum > ACC_W'(SAT_MAX)) ? SAT_MAX : dec_sum[WORD_W-1:0];
                end else if (r_in_byte == CHR_SEMI || r_in_byte == CHR_SGR) begin
                    ev_cnt   = CNT_W'(1);
                    ev_kind  = EV_STYLE;
                    ev_param = r_accum;
                    if (r_in_byte == CHR_SEMI) begin
                        n_accum = '0;
                    end else begin
                        n_state = ST_TEXT;
                    end
                end else begin
                    if (r_in_byte == CHR_FWD) begin
                        n_col   = fwd_sum[WORD_W] ? SAT_MAX : fwd_sum[WORD_W-1:0];
                        ev_cnt  = CNT_W'(1);
                        ev_kind = EV_CURSOR;
                    end else if (r_in_byte == CHR_BACK) begin
                        n_col   = (r_col > r_accum) ? (r_col - r_accum) : '0;
                        ev_cnt  = CNT_W'(1);
                        ev_kind = EV_CURSOR;
                    end
                    n_state = ST_TEXT;
                end
            end
            ST_FONT: begin
                n_state = ST_TEXT;
            end
            default: begin
                n_state = ST_TEXT;
            end
        endcase

        // end of a data block restarts the tab chunk
        if (r_in_end) begin
            n_phase = '0;
        end
    end

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_TEXT;
            r_accum    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= '0;
            r_rem      <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
                r_accum <= n_accum;
                r_col   <= n_col;
                r_row   <= n_row;
                r_phase <= n_phase;
                r_rem   <= ev_cnt;
            end else if (r_rem != '0 && o_out.ready) begin
                r_rem <= r_rem - CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.byte_value;
            r_in_end  <= i_in.block_end;
        end
        if (advance) begin
            r_kind   <= ev_kind;
            r_char   <= ev_char;
            r_param  <= ev_param;
            r_ev_col <= n_col;
            r_ev_row <= n_row;
        end
    end

    assign o_out.valid       = (r_rem != '0);
    assign o_out.event_kind  = r_kind;
    assign o_out.char_code   = r_char;
    assign o_out.style_param = r_param;
    assign o_out.column      = r_ev_col;
    assign o_out.row         = r_ev_row;
    assign o_out.last_of_run = (r_rem == CNT_W'(1));

    // a held byte stays put until the parser takes it
    `AESP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))
    // only tab expansion repeats a beat, and it repeats spaces
    `AESP_ASSERT_SAME(a_repeat_space, i_clk, i_rst_n, r_rem > CNT_W'(1), r_kind == EV_PRINT && r_char == BYTE_SPACE)
    // repeat count never exceeds a full tab stop
    `AESP_ASSERT_SAME(a_rem_range, i_clk, i_rst_n, 1'b1, r_rem <= TAB_CNT)
    // a taken repeated beat steps the count down by one
    `AESP_ASSERT_NEXT(a_rem_step, i_clk, i_rst_n, r_rem > CNT_W'(1) && o_out.ready, r_rem == $past(r_rem) - CNT_W'(1))
    // newline events always report column zero
    `AESP_ASSERT_SAME(a_nl_col, i_clk, i_rst_n, o_out.valid && r_kind == EV_NEWLINE, r_ev_col == '0)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the escape stream parser: directed byte streams, then long random streams.
// Uses aesp_pkg, aesp_in_if and aesp_out_if; keeps its own model of the parser state.

module tb_top;
    import aesp_pkg::*;

    // cursor up/down finals: CSI leaves without an event
    localparam logic [7:0] CHR_UP   = 8'h41;
    localparam logic [7:0] CHR_DOWN = 8'h42;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_DEL = 8'h7F;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;

    typedef enum logic [1:0] {
        PS_TEXT = 2'd0,
        PS_ESC  = 2'd1,
        PS_CSI  = 2'd2,
        PS_FONT = 2'd3
    } t_parse_state;

    typedef struct {
        t_event_kind       kind;
        logic [7:0]        ch;
        logic [WORD_W-1:0] param;
        logic [WORD_W-1:0] col;
        logic [WORD_W-1:0] row;
        logic              last;
    } t_event;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    aesp_in_if  in_if ();
    aesp_out_if out_if ();

    ansi_escape_stream_parser_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser state as the block should hold it
    t_parse_state        pst = PS_TEXT;
    logic [WORD_W-1:0]   acc = '0;
    logic [WORD_W-1:0]   cur_col = '0;
    logic [WORD_W-1:0]   cur_row = '0;
    logic [PHASE_W-1:0]  tab_phase = '0;

    t_event pending_events[$];

    int fail_count = 0;
    int sent_count = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int max_col_seen = 0;
    int cycle_count = 0;

    bit sender_idles = 1'b0;
    bit recv_idles = 1'b0;
    int hold_request = 0;

    function automatic void expect_event(input t_event_kind k, input logic [7:0] ch,
                                         input logic [WORD_W-1:0] p, input logic last);
        t_event ev;
        ev.kind  = k;
        ev.ch    = ch;
        ev.param = p;
        ev.col   = cur_col;
        ev.row   = cur_row;
        ev.last  = last;
        pending_events.push_back(ev);
    endfunction

    // advance the parser by one accepted byte and queue the events it causes
    function automatic void track_terminal_byte(input logic [7:0] b, input logic be);
        logic [31:0] wide;
        int spaces;
        int i;
        case (pst)
            PS_TEXT: begin
                if (b == BYTE_ESC) begin
                    tab_phase = '0;
                    pst = PS_ESC;
                end else if (b == BYTE_LF) begin
                    tab_phase = '0;
                    cur_col = '0;
                    if (cur_row != SAT_MAX) cur_row = cur_row + 1'b1;
                    expect_event(EV_NEWLINE, 8'h00, '0, 1'b1);
                end else if (b == BYTE_TAB) begin
                    spaces = TAB_STOP - int'(tab_phase);
                    for (i = 0; i < spaces; i++)
                        expect_event(EV_PRINT, BYTE_SPACE, '0, i == spaces - 1);
                    tab_phase = '0;
                end else if (b >= PRINT_LO && b <= PRINT_HI) begin
                    expect_event(EV_PRINT, b, '0, 1'b1);
                    tab_phase = tab_phase + 1'b1;
                end
            end
            PS_ESC: begin
                acc = '0;
                if (b == CHR_LBRACK) pst = PS_CSI;
                else if (b == CHR_LPAREN) pst = PS_FONT;
            end
            PS_CSI: begin
                if (b >= CHR_DIG0 && b <= CHR_DIG9) begin
                    wide = 32'(acc) * DEC_BASE + 32'(b - CHR_DIG0);
                    acc = (wide > 32'(SAT_MAX)) ? SAT_MAX : wide[WORD_W-1:0];
                end else if (b == CHR_SEMI || b == CHR_SGR) begin
                    expect_event(EV_STYLE, 8'h00, acc, 1'b1);
                    if (b == CHR_SEMI) acc = '0;
                    else pst = PS_TEXT;
                end else begin
                    if (b == CHR_FWD) begin
                        wide = 32'(cur_col) + 32'(acc);
                        cur_col = (wide > 32'(SAT_MAX)) ? SAT_MAX : wide[WORD_W-1:0];
                        expect_event(EV_CURSOR, 8'h00, '0, 1'b1);
                    end else if (b == CHR_BACK) begin
                        cur_col = (cur_col > acc) ? cur_col - acc : '0;
                        expect_event(EV_CURSOR, 8'h00, '0, 1'b1);
                    end
                    pst = PS_TEXT;
                end
            end
            default: pst = PS_TEXT;
        endcase
        if (be) tab_phase = '0;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // inputs and outputs both sampled on the rising edge; model first, then compare
    always @(posedge clk) begin : result_compare
        t_event want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                track_terminal_byte(in_if.byte_value, in_if.block_end);
            if (out_if.valid && out_if.ready) begin
                if (pending_events.size() == 0) begin
                    $error("event beat with nothing expected: kind %0d char %0h",
                           out_if.event_kind, out_if.char_code);
                    fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 16'(want.kind), 16'(out_if.event_kind));
                    check_field("char_code", 16'(want.ch), 16'(out_if.char_code));
                    check_field("style_param", want.param, out_if.style_param);
                    check_field("column", want.col, out_if.column);
                    check_field("row", want.row, out_if.row);
                    check_field("last_of_run", 16'(want.last), 16'(out_if.last_of_run));
                    kind_seen[int'(out_if.event_kind)]++;
                    if (int'(out_if.column) > max_col_seen) max_col_seen = int'(out_if.column);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, pending_events.size());
            $display("simulation failed");
            $finish;
        end
    end

    // event side: random stall bursts, plus long holds counted here
    initial begin : event_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (recv_idles && $urandom_range(0, 7) == 0) begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    // one byte beat; optional idle burst before it
    task automatic send_byte(input logic [7:0] b, input logic be);
        int gap;
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) begin
                @(negedge clk);
                in_if.valid = 1'b0;
                in_if.byte_value = 8'($urandom);
                in_if.block_end = 1'($urandom);
            end
        end
        @(negedge clk);
        in_if.valid = 1'b1;
        in_if.byte_value = b;
        in_if.block_end = be;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic rand_end();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // mostly short parameters, now and then long enough to saturate
    task automatic send_digits();
        int n;
        int pick;
        pick = $urandom_range(0, 9);
        n = (pick < 7) ? $urandom_range(0, 2) : (pick < 9) ? $urandom_range(3, 4)
                                                           : $urandom_range(5, 6);
        repeat (n) send_byte(CHR_DIG0 + 8'($urandom_range(0, 9)), rand_end());
    endtask

    task automatic send_random_sequence();
        int pick;
        int k;
        logic [7:0] fin;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_byte(8'($urandom_range(int'(PRINT_LO), int'(PRINT_HI))), rand_end());
        end else if (pick < 40) begin
            send_byte(BYTE_TAB, rand_end());
        end else if (pick < 46) begin
            send_byte(BYTE_LF, rand_end());
        end else if (pick < 66) begin
            send_byte(BYTE_ESC, rand_end());
            send_byte(CHR_LBRACK, rand_end());
            k = $urandom_range(0, 3);
            repeat (k) begin
                send_digits();
                send_byte(CHR_SEMI, rand_end());
            end
            send_digits();
            send_byte(CHR_SGR, rand_end());
        end else if (pick < 80) begin
            send_byte(BYTE_ESC, rand_end());
            send_byte(CHR_LBRACK, rand_end());
            send_digits();
            send_byte($urandom_range(0, 1) ? CHR_FWD : CHR_BACK, rand_end());
        end else if (pick < 85) begin
            // CSI ending on an up or down final, which is not handled, or on a random byte
            send_byte(BYTE_ESC, rand_end());
            send_byte(CHR_LBRACK, rand_end());
            send_digits();
            k = $urandom_range(0, 2);
            fin = (k == 0) ? CHR_UP : (k == 1) ? CHR_DOWN : 8'($urandom);
            send_byte(fin, rand_end());
        end else if (pick < 89) begin
            send_byte(BYTE_ESC, rand_end());
            send_byte(CHR_LPAREN, rand_end());
            send_byte(8'($urandom), rand_end());
        end else if (pick < 92) begin
            // junk while in escape, then a proper CSI
            send_byte(BYTE_ESC, rand_end());
            k = $urandom_range(1, 3);
            repeat (k) send_byte(8'($urandom), rand_end());
            send_byte(CHR_LBRACK, rand_end());
            send_digits();
            send_byte(CHR_SGR, rand_end());
        end else begin
            send_byte(8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_text_and_controls();
        send_byte(PRINT_LO, 1'b0);
        send_byte(PRINT_HI, 1'b0);
        send_byte(BYTE_NUL, 1'b0);
        send_byte(BYTE_DEL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(BYTE_CR, 1'b0);
        wait_drained();
    endtask

    task automatic test_tab_expansion();
        send_byte(BYTE_TAB, 1'b0);          // two spaces: phase was 2
        send_byte(8'h78, 1'b1);             // block end clears the phase
        send_byte(BYTE_TAB, 1'b0);          // full four
        send_byte(8'h79, 1'b0);
        send_byte(BYTE_LF, 1'b0);
        wait_drained();
    endtask

    task automatic test_escape_paths();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(CHR_LPAREN, 1'b0);        // font reset eats the next byte
        send_byte(CHR_SGR, 1'b0);
        send_byte(BYTE_ESC, 1'b0);
        send_byte(8'h71, 1'b0);             // unknown: stays in escape
        send_byte(CHR_LBRACK, 1'b0);
        send_byte(CHR_UP, 1'b0);
        wait_drained();
    endtask

    task automatic test_style_params();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(CHR_LBRACK, 1'b0);
        repeat (6) send_byte(CHR_DIG9, 1'b0);   // saturates the parameter
        send_byte(CHR_SEMI, 1'b0);
        send_byte(CHR_SGR, 1'b0);               // empty parameter
        wait_drained();
    endtask

    task automatic test_cursor_moves();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(CHR_LBRACK, 1'b0);
        send_byte(CHR_DIG9, 1'b0);
        send_byte(CHR_BACK, 1'b0);          // clamps at column 0
        send_byte(BYTE_ESC, 1'b0);
        send_byte(CHR_LBRACK, 1'b0);
        send_byte(CHR_DIG0 + 8'd7, 1'b0);
        send_byte(CHR_FWD, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_stream(input int upto);
        while (sent_count < upto) send_random_sequence();
        wait_drained();
    endtask

    // event side held off while bytes keep coming, so the block backs up
    task automatic test_output_backpressure();
        int start;
        start = sent_count;
        sender_idles = 1'b0;
        hold_request = 90;
        while (sent_count < start + 40) send_random_sequence();
        wait_drained();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.byte_value = '0;
        in_if.block_end = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_text_and_controls();
        test_tab_expansion();
        test_escape_paths();
        test_style_params();
        test_cursor_moves();

        sender_idles = 1'b1;
        recv_idles = 1'b1;
        test_random_stream(sent_count + 170);
        test_output_backpressure();
        sender_idles = 1'b1;
        test_random_stream(sent_count + 120);

        // closing stretch at full rate both ways
        sender_idles = 1'b0;
        recv_idles = 1'b0;
        test_random_stream(sent_count + 100);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("bytes sent %0d; events print %0d newline %0d style %0d cursor %0d",
                 sent_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("widest column reached %0d, final row %0d, mismatches %0d",
                 max_col_seen, cur_row, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
